// ----- rtl/ocwm_pkg.sv -----
// shared types, widths, constants and register codes of the omni wheel mixer
// used by every module under rtl; depends on nothing
package ocwm_pkg;

  localparam int WHEELS      = 4;
  localparam int STICK_W     = 11;
  localparam int MAG_W       = 11;
  localparam int SPEED_W     = 16;
  localparam int TOP_SPEED_W = 13;
  localparam int DEAD_ZONE_W = 10;
  localparam int ARM_W       = 10;
  localparam int SIGNS_W     = 16;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [TOP_SPEED_W-1:0] TOP_SPEED_RST   = 13'd2000;
  localparam logic [DEAD_ZONE_W-1:0] DEAD_ZONE_RST   = 10'd160;
  localparam logic [ARM_W-1:0]       ARM_Y_RST       = 10'd64;
  localparam logic [ARM_W-1:0]       ARM_X_RST       = 10'd64;
  localparam logic [SIGNS_W-1:0]     WHEEL_SIGNS_RST = 16'd58680;

  // exact floor division by 125 for numerators below 2^30
  localparam logic [30:0] RECIP_125    = 31'd1099511628;
  localparam int          RECIP_SHIFT  = 37;
  localparam logic [15:0] HALF_SQRT2_Q16 = 16'd46341;
  localparam logic [40:0] ROUND_Q24    = 41'd8388608;

  localparam logic [16:0] SAT_POS = 17'd32767;
  localparam logic [16:0] SAT_NEG = 17'd32768;
  localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 16'h7FFF;
  localparam logic [SPEED_W-1:0] SPEED_NEG_MAX = 16'h8000;

  typedef enum logic [2:0] {
    REG_TOP_SPEED   = 3'd0,
    REG_DEAD_ZONE   = 3'd1,
    REG_ARM_Y       = 3'd2,
    REG_ARM_X       = 3'd3,
    REG_WHEEL_SIGNS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [TOP_SPEED_W-1:0] top_speed;
    logic [DEAD_ZONE_W-1:0] dead_zone;
    logic [ARM_W-1:0]       arm_y_q8;
    logic [ARM_W-1:0]       arm_x_q8;
    logic [SIGNS_W-1:0]     wheel_signs;
  } cfg_t;

  // stick excess beyond the dead zone, as magnitude and sign
  typedef struct packed {
    logic [MAG_W-1:0] fwd_mag;
    logic             fwd_neg;
    logic [MAG_W-1:0] side_mag;
    logic             side_neg;
    logic [MAG_W-1:0] turn_mag;
    logic             turn_neg;
  } item_t;

endpackage

// ----- rtl/ocwm_front.sv -----
// front end: takes stick transfers, applies the dead zone and registers the excess
// depends on ocwm_pkg
module ocwm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ocwm_pkg::DEAD_ZONE_W-1:0]    dead_zone,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ocwm_pkg::STICK_W-1:0] in_stick_forward,
  input  logic signed [ocwm_pkg::STICK_W-1:0] in_stick_side,
  input  logic signed [ocwm_pkg::STICK_W-1:0] in_stick_turn,
  output logic                                item_valid,
  input  logic                                item_ready,
  output ocwm_pkg::item_t                     item
);

  logic            vld_r, vld_nxt;
  ocwm_pkg::item_t item_r, item_nxt;

  function automatic logic [ocwm_pkg::MAG_W:0] excess(
    input logic signed [ocwm_pkg::STICK_W-1:0] x,
    input logic [ocwm_pkg::DEAD_ZONE_W-1:0]    dz
  );
    logic signed [11:0] sx;
    logic [11:0]        ax;
    logic [11:0]        diff;
    sx = 12'(x);
    ax = sx[11] ? 12'(-sx) : 12'(sx);
    diff = ax - 12'(dz);
    if (ax > 12'(dz)) begin
      excess = {diff[ocwm_pkg::MAG_W-1:0], x[ocwm_pkg::STICK_W-1]};
    end else begin
      excess = '0;
    end
  endfunction

  assign in_ready   = !vld_r || item_ready;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_comb begin
    vld_nxt  = in_ready ? in_valid : vld_r;
    item_nxt = item_r;
    if (in_valid && in_ready) begin
      {item_nxt.fwd_mag, item_nxt.fwd_neg}   = excess(in_stick_forward, dead_zone);
      {item_nxt.side_mag, item_nxt.side_neg} = excess(in_stick_side, dead_zone);
      {item_nxt.turn_mag, item_nxt.turn_neg} = excess(in_stick_turn, dead_zone);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

// ----- rtl/ocwm_queue.sv -----
// short first-in first-out queue between the front end and the arithmetic pipeline
// depends on ocwm_pkg
module ocwm_queue #(
  parameter int DEPTH = ocwm_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  ocwm_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ocwm_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ocwm_pkg::item_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/ocwm_back.sv -----
// back end: six-stage elastic pipeline from stick excess to saturated wheel speeds
// depends on ocwm_pkg
module ocwm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ocwm_pkg::cfg_t                cfg,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  ocwm_pkg::item_t               item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ocwm_pkg::SPEED_W-1:0]  out_speed [ocwm_pkg::WHEELS]
);

  localparam int STAGES = 6;
  localparam int NW     = ocwm_pkg::WHEELS;

  logic [STAGES-1:0] vld_r, vld_nxt, adv;

  // stage 1: excess times full speed
  logic [23:0]        s1_m_r [3];
  logic [2:0]         s1_neg_r;
  // stage 2: scaled speeds in q8
  logic signed [23:0] s2_vx_r, s2_vy_r;
  logic [21:0]        s2_wmag_r;
  logic               s2_wneg_r;
  logic [29:0]        num_x, num_y, num_w;
  logic [60:0]        prod_x, prod_y, prod_w;
  // stage 3: turn terms
  logic signed [23:0] s3_vx_r, s3_vy_r;
  logic signed [24:0] s3_wry_r, s3_wrx_r;
  logic [31:0]        prod_ry, prod_rx;
  logic [32:0]        rnd_ry, rnd_rx;
  logic [23:0]        mag_ry, mag_rx;
  // stage 4: per-wheel sums
  logic signed [26:0] w_a [NW];
  logic signed [26:0] w_b [NW];
  logic signed [26:0] w_sum [NW];
  logic signed [26:0] w_abs [NW];
  logic [3:0]         w_sg [NW];
  logic [24:0]        s4_mag_r [NW];
  logic [NW-1:0]      s4_neg_r, s4_neg_nxt;
  // stage 5: times half root two
  logic [40:0]        s5_prod_r [NW];
  logic [NW-1:0]      s5_neg_r;
  // stage 6: rounded and saturated
  logic [40:0]        w_rnd [NW];
  logic [16:0]        w_r [NW];
  logic [16:0]        w_rn [NW];
  logic [ocwm_pkg::SPEED_W-1:0] w_spd [NW];
  logic [ocwm_pkg::SPEED_W-1:0] s6_spd_r [NW];

  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? item_valid : vld_r[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign item_ready = adv[0];
  assign out_valid  = vld_r[STAGES-1];
  assign out_speed  = s6_spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // divide by 500 and 1000 with rounding, reduced to a floor division by 125
  always_comb begin
    num_x  = {s1_m_r[0], 6'b0} + 30'd62;
    num_y  = {s1_m_r[1], 6'b0} + 30'd62;
    num_w  = 30'({s1_m_r[2], 5'b0}) + 30'd62;
    prod_x = 61'(num_x) * 61'(ocwm_pkg::RECIP_125);
    prod_y = 61'(num_y) * 61'(ocwm_pkg::RECIP_125);
    prod_w = 61'(num_w) * 61'(ocwm_pkg::RECIP_125);
  end

  always_comb begin
    prod_ry = 32'(s2_wmag_r) * 32'(cfg.arm_y_q8);
    prod_rx = 32'(s2_wmag_r) * 32'(cfg.arm_x_q8);
    rnd_ry  = 33'(prod_ry) + 33'd128;
    rnd_rx  = 33'(prod_rx) + 33'd128;
    mag_ry  = rnd_ry[31:8];
    mag_rx  = rnd_rx[31:8];
  end

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      w_sg[i]  = cfg.wheel_signs[4*i +: 4];
      w_a[i]   = 27'(s3_vx_r) + (w_sg[i][0] ? -27'(s3_wry_r) : 27'(s3_wry_r));
      w_b[i]   = 27'(s3_vy_r) + (w_sg[i][2] ? -27'(s3_wrx_r) : 27'(s3_wrx_r));
      w_sum[i] = w_a[i] + (w_sg[i][1] ? -w_b[i] : w_b[i]);
      w_abs[i] = w_sum[i][26] ? -w_sum[i] : w_sum[i];
      s4_neg_nxt[i] = w_sum[i][26] ^ w_sg[i][3];
    end
  end

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      w_rnd[i] = s5_prod_r[i] + ocwm_pkg::ROUND_Q24;
      w_r[i]   = w_rnd[i][40:24];
      w_rn[i]  = 17'(-w_r[i]);
      if (s5_neg_r[i]) begin
        w_spd[i] = (w_r[i] > ocwm_pkg::SAT_NEG) ? ocwm_pkg::SPEED_NEG_MAX
                                                : w_rn[i][ocwm_pkg::SPEED_W-1:0];
      end else begin
        w_spd[i] = (w_r[i] > ocwm_pkg::SAT_POS) ? ocwm_pkg::SPEED_POS_MAX
                                                : w_r[i][ocwm_pkg::SPEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_m_r[0] <= 24'(item.fwd_mag) * 24'(cfg.top_speed);
      s1_m_r[1] <= 24'(item.side_mag) * 24'(cfg.top_speed);
      s1_m_r[2] <= 24'(item.turn_mag) * 24'(cfg.top_speed);
      s1_neg_r  <= {item.turn_neg, item.side_neg, item.fwd_neg};
    end
    if (adv[1]) begin
      s2_vx_r   <= s1_neg_r[0] ? -$signed({1'b0, prod_x[59:37]})
                               : $signed({1'b0, prod_x[59:37]});
      s2_vy_r   <= s1_neg_r[1] ? -$signed({1'b0, prod_y[59:37]})
                               : $signed({1'b0, prod_y[59:37]});
      s2_wmag_r <= prod_w[58:37];
      s2_wneg_r <= s1_neg_r[2];
    end
    if (adv[2]) begin
      s3_vx_r  <= s2_vx_r;
      s3_vy_r  <= s2_vy_r;
      s3_wry_r <= s2_wneg_r ? -$signed({1'b0, mag_ry}) : $signed({1'b0, mag_ry});
      s3_wrx_r <= s2_wneg_r ? -$signed({1'b0, mag_rx}) : $signed({1'b0, mag_rx});
    end
    if (adv[3]) begin
      for (int i = 0; i < NW; i++) begin
        s4_mag_r[i] <= w_abs[i][24:0];
      end
      s4_neg_r <= s4_neg_nxt;
    end
    if (adv[4]) begin
      for (int i = 0; i < NW; i++) begin
        s5_prod_r[i] <= 41'(s4_mag_r[i]) * 41'(ocwm_pkg::HALF_SQRT2_Q16);
      end
      s5_neg_r <= s4_neg_r;
    end
    if (adv[5]) begin
      s6_spd_r <= w_spd;
    end
  end

endmodule

// ----- rtl/omni_chassis_wheel_mixer.sv -----
// top level of the four-wheel omni chassis mixer: apb registers, front end, queue, back end
// depends on ocwm_pkg, ocwm_front, ocwm_queue, ocwm_back
// path: an input transfer passes the front register, the queue and the back-end stages to out_valid
// throughput: one stick sample per cycle while out_ready does not stall, set by the fully pipelined back end
// the queue and output register let either side stall without losing a cycle
// synchronous reset clears all handshake state and loads the register defaults
module omni_chassis_wheel_mixer #(
  parameter int QUEUE_DEPTH = ocwm_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ocwm_pkg::ADDR_W-1:0]          paddr,
  input  logic [ocwm_pkg::DATA_W-1:0]          pwdata,
  output logic [ocwm_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ocwm_pkg::STICK_W-1:0]  in_stick_forward,
  input  logic signed [ocwm_pkg::STICK_W-1:0]  in_stick_side,
  input  logic signed [ocwm_pkg::STICK_W-1:0]  in_stick_turn,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ocwm_pkg::SPEED_W-1:0]  out_right1_speed,
  output logic signed [ocwm_pkg::SPEED_W-1:0]  out_left1_speed,
  output logic signed [ocwm_pkg::SPEED_W-1:0]  out_left2_speed,
  output logic signed [ocwm_pkg::SPEED_W-1:0]  out_right2_speed
);

  ocwm_pkg::cfg_t     cfg_r, cfg_nxt;
  ocwm_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  ocwm_pkg::item_t    front_item, queue_item;
  logic               front_valid, front_ready;
  logic               queue_valid, queue_ready;
  logic [ocwm_pkg::SPEED_W-1:0] speed [ocwm_pkg::WHEELS];

  assign pready  = 1'b1;
  assign reg_idx = ocwm_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        ocwm_pkg::REG_TOP_SPEED:   cfg_nxt.top_speed   = pwdata[ocwm_pkg::TOP_SPEED_W-1:0];
        ocwm_pkg::REG_DEAD_ZONE:   cfg_nxt.dead_zone   = pwdata[ocwm_pkg::DEAD_ZONE_W-1:0];
        ocwm_pkg::REG_ARM_Y:       cfg_nxt.arm_y_q8    = pwdata[ocwm_pkg::ARM_W-1:0];
        ocwm_pkg::REG_ARM_X:       cfg_nxt.arm_x_q8    = pwdata[ocwm_pkg::ARM_W-1:0];
        ocwm_pkg::REG_WHEEL_SIGNS: cfg_nxt.wheel_signs = pwdata[ocwm_pkg::SIGNS_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ocwm_pkg::REG_TOP_SPEED:   prdata = ocwm_pkg::DATA_W'(cfg_r.top_speed);
      ocwm_pkg::REG_DEAD_ZONE:   prdata = ocwm_pkg::DATA_W'(cfg_r.dead_zone);
      ocwm_pkg::REG_ARM_Y:       prdata = ocwm_pkg::DATA_W'(cfg_r.arm_y_q8);
      ocwm_pkg::REG_ARM_X:       prdata = ocwm_pkg::DATA_W'(cfg_r.arm_x_q8);
      ocwm_pkg::REG_WHEEL_SIGNS: prdata = ocwm_pkg::DATA_W'(cfg_r.wheel_signs);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.top_speed   <= ocwm_pkg::TOP_SPEED_RST;
      cfg_r.dead_zone   <= ocwm_pkg::DEAD_ZONE_RST;
      cfg_r.arm_y_q8    <= ocwm_pkg::ARM_Y_RST;
      cfg_r.arm_x_q8    <= ocwm_pkg::ARM_X_RST;
      cfg_r.wheel_signs <= ocwm_pkg::WHEEL_SIGNS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ocwm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .dead_zone        (cfg_r.dead_zone),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stick_forward (in_stick_forward),
    .in_stick_side    (in_stick_side),
    .in_stick_turn    (in_stick_turn),
    .item_valid       (front_valid),
    .item_ready       (front_ready),
    .item             (front_item)
  );

  ocwm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  ocwm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_speed  (speed)
  );

  assign out_right1_speed = $signed(speed[0]);
  assign out_left1_speed  = $signed(speed[1]);
  assign out_left2_speed  = $signed(speed[2]);
  assign out_right2_speed = $signed(speed[3]);

endmodule

// ----- sim/ocwm_wheel_checker.sv -----
// checker for the omni wheel mixer: follows register writes, predicts the four wheel
// speeds of every accepted stick transfer and compares them with the result transfers
// depends on ocwm_pkg
module ocwm_wheel_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ocwm_pkg::ADDR_W-1:0]         paddr,
  input  logic [ocwm_pkg::DATA_W-1:0]         pwdata,
  input  logic                                pready,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [ocwm_pkg::STICK_W-1:0] in_stick_forward,
  input  logic signed [ocwm_pkg::STICK_W-1:0] in_stick_side,
  input  logic signed [ocwm_pkg::STICK_W-1:0] in_stick_turn,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [ocwm_pkg::SPEED_W-1:0] out_right1_speed,
  input  logic signed [ocwm_pkg::SPEED_W-1:0] out_left1_speed,
  input  logic signed [ocwm_pkg::SPEED_W-1:0] out_left2_speed,
  input  logic signed [ocwm_pkg::SPEED_W-1:0] out_right2_speed,
  output int                                  errors,
  output int                                  pending,
  output int                                  checked
);

  localparam longint TRANS_DIV = 500;
  localparam longint TURN_DIV  = 1000;
  localparam longint Q8_ONE    = 256;
  localparam longint Q24_ONE   = 16777216;
  localparam longint SPEED_MAX = 32767;
  localparam longint SPEED_MIN = -32768;

  typedef logic [ocwm_pkg::WHEELS-1:0][ocwm_pkg::SPEED_W-1:0] speeds_t;

  ocwm_pkg::cfg_t regs;
  speeds_t        speeds_due [$];
  string          wheel_name [ocwm_pkg::WHEELS] =
                    '{"right1_speed", "left1_speed", "left2_speed", "right2_speed"};
  int             err_count = 0;
  int             seen = 0;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  // nearest, ties away from zero
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint beyond_zone(longint x);
    longint dz;
    dz = longint'(regs.dead_zone);
    if (x > dz) return x - dz;
    if (x < -dz) return x + dz;
    return 0;
  endfunction

  function automatic longint negate_if(logic neg, longint v);
    return neg ? -v : v;
  endfunction

  function automatic speeds_t wheel_speeds(logic signed [ocwm_pkg::STICK_W-1:0] fwd,
                                           logic signed [ocwm_pkg::STICK_W-1:0] side,
                                           logic signed [ocwm_pkg::STICK_W-1:0] turn);
    longint  ms, vx, vy, w, wry, wrx, a, b, sum, r;
    speeds_t sp;
    int      i;
    ms  = longint'(regs.top_speed);
    vx  = round_div(beyond_zone(longint'(fwd)) * ms * Q8_ONE, TRANS_DIV);
    vy  = round_div(beyond_zone(longint'(side)) * ms * Q8_ONE, TRANS_DIV);
    w   = round_div(beyond_zone(longint'(turn)) * ms * Q8_ONE, TURN_DIV);
    wry = round_div(w * longint'(regs.arm_y_q8), Q8_ONE);
    wrx = round_div(w * longint'(regs.arm_x_q8), Q8_ONE);
    for (i = 0; i < ocwm_pkg::WHEELS; i++) begin
      a   = vx + negate_if(regs.wheel_signs[4*i], wry);
      b   = vy + negate_if(regs.wheel_signs[4*i+2], wrx);
      sum = a + negate_if(regs.wheel_signs[4*i+1], b);
      r   = round_div(sum * longint'(ocwm_pkg::HALF_SQRT2_Q16), Q24_ONE);
      r   = negate_if(regs.wheel_signs[4*i+3], r);
      if (r > SPEED_MAX) r = SPEED_MAX;
      if (r < SPEED_MIN) r = SPEED_MIN;
      sp[i] = r[ocwm_pkg::SPEED_W-1:0];
    end
    return sp;
  endfunction

  always @(posedge clk) begin
    speeds_t due;
    speeds_t got;
    int      i;
    if (!rst_n) begin
      regs <= {ocwm_pkg::TOP_SPEED_RST, ocwm_pkg::DEAD_ZONE_RST, ocwm_pkg::ARM_Y_RST,
               ocwm_pkg::ARM_X_RST, ocwm_pkg::WHEEL_SIGNS_RST};
      speeds_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_right2_speed, out_left2_speed, out_left1_speed, out_right1_speed};
        seen++;
        if (speeds_due.size() == 0) begin
          err_count++;
          $error("result transfer with no stick sample outstanding");
        end else begin
          due = speeds_due.pop_front();
          for (i = 0; i < ocwm_pkg::WHEELS; i++) begin
            if (got[i] !== due[i]) begin
              err_count++;
              $error("%s: expected %0d, actual %0d", wheel_name[i],
                     $signed(due[i]), $signed(got[i]));
            end
          end
        end
      end
      if (in_valid && in_ready)
        speeds_due.push_back(wheel_speeds(in_stick_forward, in_stick_side, in_stick_turn));
      if (psel && penable && pwrite && pready) begin
        case (paddr[ocwm_pkg::ADDR_W-1:2])
          ocwm_pkg::REG_TOP_SPEED:   regs.top_speed   <= pwdata[ocwm_pkg::TOP_SPEED_W-1:0];
          ocwm_pkg::REG_DEAD_ZONE:   regs.dead_zone   <= pwdata[ocwm_pkg::DEAD_ZONE_W-1:0];
          ocwm_pkg::REG_ARM_Y:       regs.arm_y_q8    <= pwdata[ocwm_pkg::ARM_W-1:0];
          ocwm_pkg::REG_ARM_X:       regs.arm_x_q8    <= pwdata[ocwm_pkg::ARM_W-1:0];
          ocwm_pkg::REG_WHEEL_SIGNS: regs.wheel_signs <= pwdata[ocwm_pkg::SIGNS_W-1:0];
          default: ;
        endcase
      end
    end
    errors  <= err_count;
    pending <= speeds_due.size();
    checked <= seen;
  end

endmodule

// ----- sim/omni_chassis_wheel_mixer_tb.sv -----
// testbench top for the omni wheel mixer: clock, reset, register writes over apb,
// stick transfers with random gaps and output stalls, verdict from ocwm_wheel_checker
// depends on ocwm_pkg, omni_chassis_wheel_mixer and ocwm_wheel_checker
module omni_chassis_wheel_mixer_tb;

  localparam int HALF_PERIOD  = 6;
  localparam int PERIOD       = 12;
  localparam int RESET_CYCLES = 11;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 95;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 500000;
  localparam int REG_COUNT    = 5;
  localparam int REG_SLOTS    = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ocwm_pkg::ADDR_W-1:0] paddr = '0;
  logic [ocwm_pkg::DATA_W-1:0] pwdata = '0;
  logic [ocwm_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ocwm_pkg::STICK_W-1:0] in_stick_forward = '0;
  logic signed [ocwm_pkg::STICK_W-1:0] in_stick_side = '0;
  logic signed [ocwm_pkg::STICK_W-1:0] in_stick_turn = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ocwm_pkg::SPEED_W-1:0] out_right1_speed;
  logic signed [ocwm_pkg::SPEED_W-1:0] out_left1_speed;
  logic signed [ocwm_pkg::SPEED_W-1:0] out_left2_speed;
  logic signed [ocwm_pkg::SPEED_W-1:0] out_right2_speed;

  int   fail_count;
  int   results_due;
  int   results_checked;
  int   samples_sent = 0;
  int   settings_used = 0;
  int   cur_dz = ocwm_pkg::DEAD_ZONE_RST;
  logic quiet = 1'b0;

  omni_chassis_wheel_mixer dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_stick_forward(in_stick_forward), .in_stick_side(in_stick_side),
    .in_stick_turn(in_stick_turn),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_right1_speed(out_right1_speed), .out_left1_speed(out_left1_speed),
    .out_left2_speed(out_left2_speed), .out_right2_speed(out_right2_speed)
  );

  ocwm_wheel_checker wheel_check (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_stick_forward(in_stick_forward), .in_stick_side(in_stick_side),
    .in_stick_turn(in_stick_turn),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_right1_speed(out_right1_speed), .out_left1_speed(out_left1_speed),
    .out_left2_speed(out_left2_speed), .out_right2_speed(out_right2_speed),
    .errors(fail_count), .pending(results_due), .checked(results_checked)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * PERIOD);
    $display("omni_chassis_wheel_mixer_tb failed");
    $finish;
  end

  // mostly short gaps, a few long ones, none in quiet phases
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (quiet) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic signed [ocwm_pkg::STICK_W-1:0] stick_value();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 35) v = $urandom;
    else if (r < 75) v = $urandom_range(1320) - 660;
    else begin
      // around the dead zone edge
      v = cur_dz + $urandom_range(4) - 2;
      if ($urandom_range(1)) v = -v;
    end
    return v[ocwm_pkg::STICK_W-1:0];
  endfunction

  function automatic logic [31:0] with_junk(int value, int width);
    logic [31:0] junk;
    junk = $urandom;
    return (junk << width) | value;
  endfunction

  always begin
    wait (rst_n);
    out_ready <= 1'b1;
    repeat ($urandom_range(1, quiet ? 300 : 10)) @(posedge clk);
    if (idle_len() > 0) begin
      out_ready <= 1'b0;
      repeat (idle_len() + 1) @(posedge clk);
    end
  end

  task automatic send_sample(input int fwd, input int side, input int turn);
    int gap;
    in_valid         <= 1'b1;
    in_stick_forward <= fwd[ocwm_pkg::STICK_W-1:0];
    in_stick_side    <= side[ocwm_pkg::STICK_W-1:0];
    in_stick_turn    <= turn[ocwm_pkg::STICK_W-1:0];
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result transfer has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
    @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int ms, input int dz, input int ay, input int ax,
                               input int ws);
    drain();
    reg_write(ocwm_pkg::REG_TOP_SPEED, with_junk(ms, ocwm_pkg::TOP_SPEED_W));
    reg_write(ocwm_pkg::REG_DEAD_ZONE, with_junk(dz, ocwm_pkg::DEAD_ZONE_W));
    reg_write(ocwm_pkg::REG_ARM_Y, with_junk(ay, ocwm_pkg::ARM_W));
    reg_write(ocwm_pkg::REG_ARM_X, with_junk(ax, ocwm_pkg::ARM_W));
    reg_write(ocwm_pkg::REG_WHEEL_SIGNS, with_junk(ws, ocwm_pkg::SIGNS_W));
    cur_dz = dz;
    settings_used++;
  endtask

  initial begin
    int phase;
    int n;
    int k;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    send_sample(0, 0, 0);
    send_sample(160, -160, 160);
    send_sample(161, -161, -161);
    send_sample(660, 0, 0);
    send_sample(0, -660, 0);
    send_sample(0, 0, 660);
    send_sample(-660, 660, -660);
    send_sample(1023, -1024, 1023);
    send_sample(-1024, 1023, -1024);

    // saturation both ways
    apply_setting(8191, 0, 1023, 1023, 0);
    send_sample(1023, 1023, 1023);
    send_sample(-1024, -1024, -1024);
    send_sample(1, -1, 1);
    send_sample(0, 0, -1024);
    apply_setting(8191, 0, 1023, 1023, 16'hFFFF);
    send_sample(1023, 1023, 1023);
    send_sample(-1024, -1024, -1024);
    send_sample(0, 0, 1023);

    apply_setting(0, 1023, 0, 0, 16'h5A5A);
    send_sample(1023, -1024, -1024);
    send_sample(-1024, -1024, -1024);
    apply_setting(2000, 1023, 64, 64, 16'hA5A5);
    send_sample(-1024, -1024, -1024);
    send_sample(1023, 1023, 1023);

    // writes beyond the register map must change nothing
    drain();
    for (k = REG_COUNT; k < REG_SLOTS; k++) reg_write(k[2:0], $urandom);
    send_sample(500, -300, 200);

    for (phase = 0; phase < PHASES; phase++) begin
      quiet = (phase % 4 == 1);
      case (phase)
        0: apply_setting(ocwm_pkg::TOP_SPEED_RST, ocwm_pkg::DEAD_ZONE_RST,
                         ocwm_pkg::ARM_Y_RST, ocwm_pkg::ARM_X_RST,
                         ocwm_pkg::WHEEL_SIGNS_RST);
        1: apply_setting(8191, 0, 1023, 1023, $urandom_range(65535));
        2: apply_setting(8000, 660, 0, 0, $urandom_range(65535));
        3: apply_setting(1, 1023, 1023, 0, $urandom_range(65535));
        default: apply_setting($urandom_range(3) == 0 ? $urandom_range(8191)
                                                      : $urandom_range(8000),
                               $urandom_range(3) == 0 ? $urandom_range(1023)
                                                      : $urandom_range(660),
                               $urandom_range(1023), $urandom_range(1023),
                               $urandom_range(65535));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(stick_value(), stick_value(), stick_value());
        if ($urandom_range(199) == 0) drain();
      end
    end
    quiet = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("%0d stick samples sent under %0d register settings, %0d wheel results checked",
             samples_sent, settings_used, results_checked);
    $display("covered dead zone edges, saturation, sign tables and unmapped register writes");
    if (fail_count == 0 && results_due == 0)
      $display("omni_chassis_wheel_mixer_tb passed");
    else
      $display("omni_chassis_wheel_mixer_tb failed");
    $finish;
  end

endmodule
